>>> rtl/core/nfjh_pkg.sv
`timescale 1ns / 1ps

package nfjh_pkg;

    localparam int HIST_BINS = 64;
    localparam int BIN_W     = $clog2(HIST_BINS);

    localparam int SAMPLE_W = 10;
    localparam int STAMP_W  = 32;
    localparam int COEF_W   = 16;
    localparam int Y_W      = 16;
    localparam int JIT_W    = 28;
    localparam int QUOT_W   = 27;
    localparam int CNT_W    = 32;
    localparam int ACC_W    = 35;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 144;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_OUTER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_MID     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_FB_ONE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_FB_TWO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS = 3'd4;

    localparam logic signed [COEF_W-1:0] COEF_OUTER_RST  = 16'sd256;
    localparam logic signed [COEF_W-1:0] COEF_MID_RST    = -16'sd503;
    localparam logic signed [COEF_W-1:0] COEF_FB_ONE_RST = 16'sd498;
    localparam logic signed [COEF_W-1:0] COEF_FB_TWO_RST = -16'sd251;
    // 25000 ticks / 50
    localparam logic [QUOT_W-1:0]        PERIOD_Q_RST    = 27'd500;
    localparam logic signed [JIT_W-1:0]  MIN_SEEN_RST    = 28'sd10000000;

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = 35'sd128;
    localparam logic signed [ACC_W-1:0] TRUNC_FIX  = 35'sd255;

    // ceil(2^35 / 25); exact floor(t / 25) for any t below 2^31
    localparam logic [30:0] DIV25_MAGIC = 31'd1374389535;

    // floor(x / 50) as floor(floor(x / 2) / 25)
    function automatic logic [QUOT_W-1:0] div50(input logic [STAMP_W-1:0] x);
        logic [61:0] prod;
        prod = 62'(x[STAMP_W-1:1]) * 62'(DIV25_MAGIC);
        return prod[61:35];
    endfunction

endpackage

>>> rtl/core/notch_filter_with_jitter_histogram.sv
`timescale 1ns / 1ps

// Notch filter with sampling jitter statistics.
// Slave stream: one beat per ADC sample; s_tdata holds the sample and its tick
// stamp, s_tuser is the run-open flag. Beats with the flag low are taken and
// dropped without a result.
// Master stream: one beat per kept sample with the filter output, the jitter in
// microseconds, the running extremes and the histogram bin that was bumped;
// m_tuser flags that jitter and histogram were updated (low on the first kept
// sample after reset).
// Config channel: cfg_index / cfg_data write the coefficients and the expected
// period; always ready; the user must write them only while the block is empty, the block itself does not enforce it.
// Throughput: one beat per cycle while the master side does not stall. The result
// passes the input register, filter/jitter logic and histogram read, the middle
// register, then count update and output register; the recursive multiply-add of
// the filter is combinational.
// A stalled master backs up through the three registers; the slave side keeps
// taking beats while any of them is free.
// Reset clears the filter history, the extremes, the histogram valid bits and
// restores the default coefficients and period.
module notch_filter_with_jitter_histogram
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [9:0] sample, [41:10] stamp, [47:42] zero
    input  logic [nfjh_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] run_open
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] filtered, [43:16] jitter_us, [71:44] jitter_max,
    // [99:72] jitter_min, [105:100] bin_index, [137:106] bin_count, [143:138] zero
    output logic [nfjh_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] jitter_valid
    output logic                            m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [nfjh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nfjh_pkg::CFG_DATA_W-1:0] cfg_data
);

    import nfjh_pkg::*;

    // configuration
    logic signed [COEF_W-1:0] coef_outer_reg;
    logic signed [COEF_W-1:0] coef_mid_reg;
    logic signed [COEF_W-1:0] coef_fb_one_reg;
    logic signed [COEF_W-1:0] coef_fb_two_reg;
    logic [QUOT_W-1:0]        period_q_reg;

    // filter and timing state
    logic [SAMPLE_W-1:0]      x1_reg;
    logic [SAMPLE_W-1:0]      x2_reg;
    logic signed [Y_W-1:0]    y1_reg;
    logic signed [Y_W-1:0]    y2_reg;
    logic [STAMP_W-1:0]       prev_stamp_reg;
    logic                     first_seen_reg;
    logic signed [JIT_W-1:0]  max_seen_reg;
    logic signed [JIT_W-1:0]  min_seen_reg;

    // input stage
    logic                     s1_valid_reg;
    logic [SAMPLE_W-1:0]      s1_sample_reg;
    logic [STAMP_W-1:0]       s1_diff_reg;
    logic                     s1_jv_reg;

    // middle stage
    logic                     s2_valid_reg;
    logic signed [Y_W-1:0]    s2_y_reg;
    logic                     s2_jv_reg;
    logic signed [JIT_W-1:0]  s2_jit_reg;
    logic [BIN_W-1:0]         s2_idx_reg;
    logic                     s2_base_vld_reg;
    logic                     s2_fwd_reg;
    logic [CNT_W-1:0]         s2_fwd_cnt_reg;
    logic [CNT_W-1:0]         bin_q_reg;

    // histogram
    logic [CNT_W-1:0]         bins_mem [HIST_BINS];
    logic [HIST_BINS-1:0]     bin_vld_reg;

    // output stage
    logic                     out_valid_reg;
    logic signed [Y_W-1:0]    out_y_reg;
    logic                     out_jv_reg;
    logic signed [JIT_W-1:0]  out_jit_reg;
    logic signed [JIT_W-1:0]  out_max_reg;
    logic signed [JIT_W-1:0]  out_min_reg;
    logic [BIN_W-1:0]         out_idx_reg;
    logic [CNT_W-1:0]         out_cnt_reg;

    logic                     s_take;
    logic                     s1_move;
    logic                     s2_move;

    logic [SAMPLE_W:0]              xsum;
    logic signed [27:0]             p_outer;
    logic signed [26:0]             p_mid;
    logic signed [31:0]             p_fb_one;
    logic signed [31:0]             p_fb_two;
    logic signed [ACC_W-1:0]        acc;
    logic signed [ACC_W-1:0]        acc_adj;
    logic signed [Y_W-1:0]          y_next;

    logic [QUOT_W-1:0]              diff_q;
    logic signed [JIT_W-1:0]        jit_next;
    logic signed [JIT_W-1:0]        pos;
    logic [BIN_W-1:0]               idx_next;

    logic [CNT_W-1:0]               base_cnt;
    logic [CNT_W-1:0]               cnt_next;
    logic signed [JIT_W-1:0]        max_next;
    logic signed [JIT_W-1:0]        min_next;
    logic                           fwd_next;

    // stage handshakes
    assign s2_move  = s2_valid_reg && (!out_valid_reg || m_tready);
    assign s1_move  = s1_valid_reg && (!s2_valid_reg || s2_move);
    assign s_tready = !s1_valid_reg || s1_move;
    assign s_take   = s_tvalid && s_tready && s_tuser;

    assign cfg_ready = 1'b1;

    // filter: rounded, truncated toward zero, wrapped to 16 bits
    always_comb
    begin
        xsum     = {1'b0, s1_sample_reg} + {1'b0, x2_reg};
        p_outer  = coef_outer_reg * $signed({1'b0, xsum});
        p_mid    = coef_mid_reg * $signed({1'b0, x1_reg});
        p_fb_one = coef_fb_one_reg * y1_reg;
        p_fb_two = coef_fb_two_reg * y2_reg;
        acc      = ACC_W'(p_outer) + ACC_W'(p_mid) + ACC_W'(p_fb_one)
                 + ACC_W'(p_fb_two) + ROUND_BIAS;
        acc_adj  = acc[ACC_W-1] ? acc + TRUNC_FIX : acc;
        y_next   = acc_adj[Y_W+7:8];
    end

    // jitter and clamped bin
    always_comb
    begin
        diff_q = div50(s1_diff_reg);
        if (s1_jv_reg)
            jit_next = $signed({1'b0, diff_q}) - $signed({1'b0, period_q_reg});
        else
            jit_next = '0;
        pos = jit_next + $signed(JIT_W'(HIST_BINS / 2));
        if (!s1_jv_reg || pos[JIT_W-1])
            idx_next = '0;
        else if (pos > $signed(JIT_W'(HIST_BINS - 1)))
            idx_next = BIN_W'(HIST_BINS - 1);
        else
            idx_next = pos[BIN_W-1:0];
    end

    // count update and extremes
    always_comb
    begin
        if (s2_fwd_reg)
            base_cnt = s2_fwd_cnt_reg;
        else if (s2_base_vld_reg)
            base_cnt = bin_q_reg;
        else
            base_cnt = '0;
        cnt_next = s2_jv_reg ? base_cnt + CNT_W'(1) : '0;
        max_next = (s2_jv_reg && (s2_jit_reg > max_seen_reg)) ? s2_jit_reg : max_seen_reg;
        min_next = (s2_jv_reg && (s2_jit_reg < min_seen_reg)) ? s2_jit_reg : min_seen_reg;
        // same-edge write to the bin being read
        fwd_next = s2_move && s2_jv_reg && (s2_idx_reg == idx_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_outer_reg  <= COEF_OUTER_RST;
            coef_mid_reg    <= COEF_MID_RST;
            coef_fb_one_reg <= COEF_FB_ONE_RST;
            coef_fb_two_reg <= COEF_FB_TWO_RST;
            period_q_reg    <= PERIOD_Q_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_COEF_OUTER:   coef_outer_reg  <= cfg_data[COEF_W-1:0];
                REG_COEF_MID:     coef_mid_reg    <= cfg_data[COEF_W-1:0];
                REG_COEF_FB_ONE:  coef_fb_one_reg <= cfg_data[COEF_W-1:0];
                REG_COEF_FB_TWO:  coef_fb_two_reg <= cfg_data[COEF_W-1:0];
                REG_PERIOD_TICKS: period_q_reg    <= div50(cfg_data);
                default:          ;
            endcase
        end
    end

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_stamp_reg <= '0;
            first_seen_reg <= 1'b0;
            x1_reg         <= '0;
            x2_reg         <= '0;
            y1_reg         <= '0;
            y2_reg         <= '0;
            max_seen_reg   <= '0;
            min_seen_reg   <= MIN_SEEN_RST;
            bin_vld_reg    <= '0;
        end
        else
        begin
            if (s_take)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;

            if (s1_move)
                s2_valid_reg <= 1'b1;
            else if (s2_move)
                s2_valid_reg <= 1'b0;

            if (s2_move)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (s_take)
            begin
                prev_stamp_reg <= s_tdata[41:10];
                first_seen_reg <= 1'b1;
            end

            if (s1_move)
            begin
                x1_reg <= s1_sample_reg;
                x2_reg <= x1_reg;
                y1_reg <= y_next;
                y2_reg <= y1_reg;
            end

            if (s2_move)
            begin
                max_seen_reg <= max_next;
                min_seen_reg <= min_next;
                if (s2_jv_reg)
                    bin_vld_reg[s2_idx_reg] <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            s1_sample_reg <= s_tdata[SAMPLE_W-1:0];
            s1_diff_reg   <= s_tdata[41:10] - prev_stamp_reg;
            s1_jv_reg     <= first_seen_reg;
        end

        if (s1_move)
        begin
            s2_y_reg        <= y_next;
            s2_jv_reg       <= s1_jv_reg;
            s2_jit_reg      <= jit_next;
            s2_idx_reg      <= idx_next;
            s2_base_vld_reg <= bin_vld_reg[idx_next];
            s2_fwd_reg      <= fwd_next;
            s2_fwd_cnt_reg  <= cnt_next;
        end

        if (s2_move)
        begin
            out_y_reg   <= s2_y_reg;
            out_jv_reg  <= s2_jv_reg;
            out_jit_reg <= s2_jit_reg;
            out_max_reg <= max_next;
            out_min_reg <= min_next;
            out_idx_reg <= s2_idx_reg;
            out_cnt_reg <= cnt_next;
        end
    end

    // histogram memory: read-before-write, same-edge hits go through s2_fwd_reg
    always_ff @(posedge clk)
    begin
        if (s2_move && s2_jv_reg)
            bins_mem[s2_idx_reg] <= cnt_next;
        if (s1_move)
            bin_q_reg <= bins_mem[idx_next];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_jv_reg;
    assign m_tdata  = {6'd0, out_cnt_reg, 6'(out_idx_reg), out_min_reg, out_max_reg,
                       out_jit_reg, out_y_reg};

endmodule
